// ===== rtl/string_escape_decoder_assert.svh =====
// Assertion macros for the string escape decoder.
`ifndef STRING_ESCAPE_DECODER_ASSERT_SVH
`define STRING_ESCAPE_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SED_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SED_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sed_pkg.sv =====
`default_nettype none

package sed_pkg;

    // Default escape lengths
    localparam int HEX_DIGITS_DEF = 4;
    localparam int OCT_DIGITS_DEF = 3;

    // Decoder mode codes
    localparam logic [2:0] MODE_TEXT = 3'd0;
    localparam logic [2:0] MODE_ESC  = 3'd1;
    localparam logic [2:0] MODE_UNI  = 3'd2;
    localparam logic [2:0] MODE_OCT  = 3'd3;

    // Characters of interest
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_0         = 8'h30;
    localparam logic [7:0] CH_7         = 8'h37;
    localparam logic [15:0] BYTE_MAX    = 16'h00FF;
    localparam logic [15:0] HEX_SAT_LIM = 16'h0FFF;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_string;
    } sed_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       string_done;
        logic       last_of_run;
    } sed_out_t;

    // Up to two results produced by one input word
    typedef struct packed {
        logic [1:0] cnt;
        sed_out_t   r0;
        sed_out_t   r1;
    } sed_res_list_t;

    // Append one result to the list; a third one is dropped
    function automatic sed_res_list_t add_res(sed_res_list_t l, logic [7:0] b, logic p);
        sed_res_list_t o;
        sed_out_t      r;
        o = l;
        r.out_byte     = p ? b : 8'h00;
        r.byte_present = p;
        r.string_done  = 1'b0;
        r.last_of_run  = 1'b0;
        if (l.cnt == 2'd0) begin
            o.r0  = r;
            o.cnt = 2'd1;
        end else if (l.cnt == 2'd1) begin
            o.r1  = r;
            o.cnt = 2'd2;
        end
        return o;
    endfunction

    // Emit the pending escape value, if any
    function automatic sed_res_list_t flush_res(sed_res_list_t l, logic [2:0] mode,
                                                logic [15:0] val);
        sed_res_list_t o;
        o = l;
        if (mode == MODE_UNI) begin
            o = add_res(l, val[7:0], val <= BYTE_MAX);
        end else if (mode == MODE_OCT) begin
            o = add_res(l, val[7:0], 1'b1);
        end
        return o;
    endfunction

    // Hex digit: {valid, value}
    function automatic logic [4:0] hex_digit(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    // Single-character escape: {valid, byte}
    function automatic logic [8:0] simple_esc(logic [7:0] c);
        logic [8:0] r;
        unique case (c)
            8'h62:   r = {1'b1, 8'h08};
            8'h74:   r = {1'b1, 8'h09};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h66:   r = {1'b1, 8'h0C};
            8'h72:   r = {1'b1, 8'h0D};
            8'h22:   r = {1'b1, 8'h22};
            8'h27:   r = {1'b1, 8'h27};
            8'h5C:   r = {1'b1, 8'h5C};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sed_decode.sv =====
`default_nettype none

module sed_decode import sed_pkg::*; #(
    parameter int HEX_DIGITS = HEX_DIGITS_DEF,
    parameter int OCT_DIGITS = OCT_DIGITS_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    fire,
    input  wire sed_in_t in_word,
    output sed_res_list_t res
);

    localparam int MAX_DIG = (HEX_DIGITS > OCT_DIGITS) ? HEX_DIGITS : OCT_DIGITS;
    localparam int DIG_W   = $clog2(MAX_DIG + 1);
    localparam logic OCT_SINGLE = (OCT_DIGITS <= 1);

    logic [2:0]       mode_reg, mode_next;
    logic [15:0]      val_reg, val_next;
    logic [DIG_W-1:0] dig_reg, dig_next;
    logic [DIG_W-1:0] dig_inc;
    logic [7:0]       c;
    logic             e;
    logic [4:0]       hx;
    logic [8:0]       se;
    logic             is_oct;
    logic             do_text;
    sed_res_list_t    l;

    assign c       = in_word.char_byte;
    assign e       = in_word.end_of_string;
    assign hx      = hex_digit(c);
    assign se      = simple_esc(c);
    assign is_oct  = (c >= CH_0) && (c <= CH_7);
    assign dig_inc = dig_reg + DIG_W'(1);

    // Decode one word against the pending escape
    always_comb begin
        l         = '0;
        mode_next = mode_reg;
        val_next  = val_reg;
        dig_next  = dig_reg;
        do_text   = 1'b0;
        unique case (mode_reg)
            MODE_ESC: begin
                mode_next = MODE_TEXT;
                val_next  = '0;
                dig_next  = '0;
                if (se[8]) begin
                    l = add_res(l, se[7:0], 1'b1);
                end else if (c == CH_U) begin
                    mode_next = MODE_UNI;
                end else if (is_oct) begin
                    if (OCT_SINGLE) begin
                        l = add_res(l, {5'd0, c[2:0]}, 1'b1);
                    end else begin
                        mode_next = MODE_OCT;
                        val_next  = {13'd0, c[2:0]};
                        dig_next  = DIG_W'(1);
                    end
                end else begin
                    l = add_res(l, c, 1'b1);
                end
            end
            MODE_UNI: begin
                if (c == CH_U && dig_reg == '0) begin
                    // extra u: hold
                end else if (hx[4]) begin
                    val_next = (val_reg > HEX_SAT_LIM) ? 16'hFFFF : {val_reg[11:0], hx[3:0]};
                    dig_next = dig_inc;
                    if (dig_inc >= DIG_W'(HEX_DIGITS)) begin
                        l         = flush_res(l, MODE_UNI, val_next);
                        mode_next = MODE_TEXT;
                        val_next  = '0;
                        dig_next  = '0;
                    end
                end else begin
                    l         = flush_res(l, MODE_UNI, val_reg);
                    mode_next = MODE_TEXT;
                    val_next  = '0;
                    dig_next  = '0;
                    do_text   = 1'b1;
                end
            end
            MODE_OCT: begin
                if (is_oct) begin
                    val_next = {val_reg[12:0], c[2:0]};
                    dig_next = dig_inc;
                    if (dig_inc >= DIG_W'(OCT_DIGITS)) begin
                        l         = flush_res(l, MODE_OCT, val_next);
                        mode_next = MODE_TEXT;
                        val_next  = '0;
                        dig_next  = '0;
                    end
                end else begin
                    l         = flush_res(l, MODE_OCT, val_reg);
                    mode_next = MODE_TEXT;
                    val_next  = '0;
                    dig_next  = '0;
                    do_text   = 1'b1;
                end
            end
            default: begin
                mode_next = MODE_TEXT;
                do_text   = 1'b1;
            end
        endcase

        // Plain text; an opening backslash starts an escape
        if (do_text) begin
            if (c != CH_BACKSLASH || e) begin
                l = add_res(l, c, 1'b1);
            end else begin
                mode_next = MODE_ESC;
            end
        end

        // Flush whatever is pending at end of string
        if (e) begin
            l         = flush_res(l, mode_next, val_next);
            mode_next = MODE_TEXT;
            val_next  = '0;
            dig_next  = '0;
        end

        // Every word gives at least one result
        if (l.cnt == 2'd0) begin
            l = add_res(l, 8'h00, 1'b0);
        end

        // Mark the last result of the run
        if (l.cnt == 2'd1) begin
            l.r0.last_of_run = 1'b1;
            l.r0.string_done = e;
        end else begin
            l.r1.last_of_run = 1'b1;
            l.r1.string_done = e;
        end
    end

    assign res = l;

    // Advance escape state on each decoded word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_TEXT;
            val_reg  <= '0;
            dig_reg  <= '0;
        end else if (fire) begin
            mode_reg <= mode_next;
            val_reg  <= val_next;
            dig_reg  <= dig_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sed_out_buf.sv =====
`default_nettype none

module sed_out_buf import sed_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          load,
    input  wire sed_res_list_t res,
    output logic               can_load,
    output logic               m_valid,
    input  wire logic          m_ready,
    output sed_out_t           m_data
);

    sed_out_t head_reg, tail_reg;
    logic     head_vld_reg, tail_vld_reg;

    // Take a new run once the buffer drains this cycle
    assign can_load = !head_vld_reg || (m_ready && !tail_vld_reg);
    assign m_valid  = head_vld_reg;
    assign m_data   = head_reg;

    // Load a run or shift the second result forward
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_vld_reg <= 1'b0;
            tail_vld_reg <= 1'b0;
        end else if (load) begin
            head_vld_reg <= 1'b1;
            tail_vld_reg <= (res.cnt == 2'd2);
        end else if (head_vld_reg && m_ready) begin
            head_vld_reg <= tail_vld_reg;
            tail_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            head_reg <= res.r0;
            tail_reg <= res.r1;
        end else if (head_vld_reg && m_ready) begin
            head_reg <= tail_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/string_escape_decoder.sv =====
// Each accepted word is held in the input register, decoded and loaded into the result buffer.
// Throughput: one word per cycle while m_ready is high; a word with two results holds
// the input while the two-entry result buffer drains.
// Reset: aresetn synchronous, active low; clears the escape state to plain text
// and empties the input and result registers.
`default_nettype none
`include "string_escape_decoder_assert.svh"

module string_escape_decoder import sed_pkg::*; #(
    parameter int HEX_DIGITS = HEX_DIGITS_DEF,
    parameter int OCT_DIGITS = OCT_DIGITS_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire sed_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output sed_out_t     m_data
);

    sed_in_t       in_data_reg;
    logic          in_vld_reg;
    logic          can_load;
    logic          fire;
    sed_res_list_t res;

    assign fire    = in_vld_reg && can_load;
    assign s_ready = !in_vld_reg || fire;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    sed_decode #(
        .HEX_DIGITS(HEX_DIGITS),
        .OCT_DIGITS(OCT_DIGITS)
    ) u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .in_word (in_data_reg),
        .res     (res)
    );

    sed_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .res      (res),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // Checks
    `SED_ASSERT_NEXT(a_fire_shows, aclk, aresetn, fire, m_valid, "decoded word not presented")
    `SED_ASSERT_NEXT(a_run_whole, aclk, aresetn, m_valid && m_ready && !m_data.last_of_run, m_valid, "run broken")
    `SED_ASSERT_NOW(a_done_last, aclk, aresetn, m_valid && m_data.string_done, m_data.last_of_run, "done not on last")
    `SED_ASSERT_NOW(a_empty_zero, aclk, aresetn, m_valid && !m_data.byte_present, m_data.out_byte == 8'h00, "empty word nonzero")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import sed_pkg::*;

    localparam int WORD_COUNT  = 1000;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN       = 16;
    localparam int SHOW_MAX    = 10;

    // Tracks the escape state, predicts the result words of each input word
    // and checks them in order as they leave the block.
    class escape_scoreboard;
        logic [2:0]  mode;
        logic [15:0] acc;
        int          ndig;
        sed_out_t    step_q[$];
        sed_out_t    expected_q[$];
        int          mismatches;

        function new();
            mismatches = 0;
            clear_escape();
        endfunction

        function void clear_escape();
            mode = MODE_TEXT;
            acc  = 16'h0000;
            ndig = 0;
        endfunction

        // Append one result word for the current input; a third is dropped
        function void add_byte(logic [7:0] b, logic present);
            sed_out_t r;
            if (step_q.size() < 2) begin
                r.out_byte     = present ? b : 8'h00;
                r.byte_present = present;
                r.string_done  = 1'b0;
                r.last_of_run  = 1'b0;
                step_q.insert(step_q.size(), r);
            end
        endfunction

        // Emit whatever the pending escape has gathered, then drop it
        function void flush_escape();
            if (mode == MODE_UNI) begin
                add_byte(acc[7:0], acc <= BYTE_MAX);
            end else if (mode == MODE_OCT) begin
                add_byte(acc[7:0], 1'b1);
            end
            clear_escape();
        endfunction

        // Plain text: a backslash opens an escape unless it ends the string
        function void take_text(logic [7:0] c, logic fin);
            if (c != CH_BACKSLASH || fin) begin
                add_byte(c, 1'b1);
            end else begin
                mode = MODE_ESC;
            end
        endfunction

        function int hex_of(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c) - int'("0");
            if (c >= "a" && c <= "f") return 10 + int'(c) - int'("a");
            if (c >= "A" && c <= "F") return 10 + int'(c) - int'("A");
            return -1;
        endfunction

        // First byte after a backslash
        function void take_escape(logic [7:0] c);
            logic [7:0] m;
            logic       simple;
            simple = 1'b1;
            m      = 8'h00;
            case (c)
                "b":     m = 8'h08;
                "t":     m = 8'h09;
                "n":     m = 8'h0A;
                "f":     m = 8'h0C;
                "r":     m = 8'h0D;
                "\"":    m = 8'h22;
                "'":     m = 8'h27;
                "\\":    m = 8'h5C;
                default: simple = 1'b0;
            endcase
            if (simple) begin
                add_byte(m, 1'b1);
                clear_escape();
            end else if (c == CH_U) begin
                mode = MODE_UNI;
                acc  = 16'h0000;
                ndig = 0;
            end else if (c >= CH_0 && c <= CH_7) begin
                mode = MODE_OCT;
                acc  = {13'd0, 3'(c - CH_0)};
                ndig = 1;
                if (ndig >= OCT_DIGITS_DEF) flush_escape();
            end else begin
                // unknown escape yields the character itself
                add_byte(c, 1'b1);
                clear_escape();
            end
        endfunction

        function void note_word(sed_in_t w);
            logic [7:0] c;
            logic       fin;
            int         d;
            c   = w.char_byte;
            fin = w.end_of_string;
            step_q.delete();
            case (mode)
                MODE_ESC: take_escape(c);
                MODE_UNI: begin
                    d = hex_of(c);
                    if (c == CH_U && ndig == 0) begin
                        // extra u's of the escape carry nothing
                    end else if (d >= 0) begin
                        if (acc > HEX_SAT_LIM) begin
                            acc = 16'hFFFF;
                        end else begin
                            acc = {acc[11:0], 4'(d)};
                        end
                        ndig++;
                        if (ndig >= HEX_DIGITS_DEF) flush_escape();
                    end else begin
                        flush_escape();
                        take_text(c, fin);
                    end
                end
                MODE_OCT: begin
                    if (c >= CH_0 && c <= CH_7) begin
                        acc = {acc[12:0], 3'(c - CH_0)};
                        ndig++;
                        if (ndig >= OCT_DIGITS_DEF) flush_escape();
                    end else begin
                        flush_escape();
                        take_text(c, fin);
                    end
                end
                default: begin
                    mode = MODE_TEXT;
                    take_text(c, fin);
                end
            endcase
            // end of string flushes any pending escape
            if (fin) flush_escape();
            if (step_q.size() == 0) add_byte(8'h00, 1'b0);
            step_q[step_q.size() - 1].last_of_run = 1'b1;
            step_q[step_q.size() - 1].string_done = fin;
            foreach (step_q[i]) expected_q.insert(expected_q.size(), step_q[i]);
        endfunction

        function void check_result(sed_out_t got);
            sed_out_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected word: byte=%h present=%b done=%b last=%b",
                             got.out_byte, got.byte_present, got.string_done,
                             got.last_of_run);
            end else begin
                want = expected_q.pop_front();
                if (got.out_byte !== want.out_byte ||
                    got.byte_present !== want.byte_present ||
                    got.string_done !== want.string_done ||
                    got.last_of_run !== want.last_of_run) begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display({"mismatch: expected byte=%h present=%b done=%b last=%b,",
                                  " got byte=%h present=%b done=%b last=%b"},
                                 want.out_byte, want.byte_present, want.string_done,
                                 want.last_of_run, got.out_byte, got.byte_present,
                                 got.string_done, got.last_of_run);
                end
            end
        endfunction
    endclass

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sed_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    sed_out_t m_data;

    escape_scoreboard sb = new();
    int               sent_words = 0;
    int               cycles = 0;
    bit               steady = 1'b0;
    logic [7:0]       text_q[$];

    string HEX_CHARS = "0123456789abcdefABCDEF";
    string ESC_CHARS = "btnfr\"'\\";

    string_escape_decoder u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Note accepted input words and check accepted result words
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_word(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // Hang guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[string_escape_decoder] ERROR");
            $finish;
        end
    end

    // Stall the result side at random
    initial begin
        int stall;
        int run;
        @(posedge aresetn);
        forever begin
            stall = pick_gap();
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            run = $urandom_range(1, 24);
            repeat (run) begin
                @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Entered at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(logic [7:0] c, logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid                <= 1'b1;
        s_data.char_byte       <= c;
        s_data.end_of_string   <= fin;
        do @(posedge aclk); while (!s_ready);
        sent_words++;
        @(negedge aclk);
    endtask

    task automatic send_string(string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
    endtask

    task automatic send_text_q();
        foreach (text_q[i]) send_word(text_q[i], i == text_q.size() - 1);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        if ($urandom_range(0, 99) < 85) begin
            c = 8'($urandom_range(32, 126));
            if (c == CH_BACKSLASH) c = "A";
        end else begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // Build one string body of plain text, well-formed and malformed escapes and random bytes
    task automatic build_string();
        int ntok;
        int ndig;
        bit lowval;
        text_q.delete();
        ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        repeat (ntok) begin
            case ($urandom_range(0, 9))
                0, 1, 2: repeat ($urandom_range(1, 3)) text_q.insert(text_q.size(), plain_char());
                3: begin
                    text_q.insert(text_q.size(), CH_BACKSLASH);
                    text_q.insert(text_q.size(), ESC_CHARS[$urandom_range(0, 7)]);
                end
                4: begin
                    text_q.insert(text_q.size(), CH_BACKSLASH);
                    repeat ($urandom_range(1, 3))
                        text_q.insert(text_q.size(), 8'(CH_0 + $urandom_range(0, 7)));
                end
                5, 6: begin
                    text_q.insert(text_q.size(), CH_BACKSLASH);
                    repeat ($urandom_range(1, 3)) text_q.insert(text_q.size(), CH_U);
                    ndig   = $urandom_range(0, 4);
                    lowval = $urandom_range(0, 1);
                    for (int i = 0; i < ndig; i++) begin
                        if (i < 2 && lowval && ndig == 4) text_q.insert(text_q.size(), "0");
                        else text_q.insert(text_q.size(), HEX_CHARS[$urandom_range(0, 21)]);
                    end
                end
                7: begin
                    text_q.insert(text_q.size(), CH_BACKSLASH);
                    text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
                end
                8: text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
                default: text_q.insert(text_q.size(), CH_BACKSLASH);
            endcase
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: byte extremes, unknown escape, trailing backslash,
        // wide octal, dropped wide unicode, empty unicode, truncated octal at end
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        send_string("\\q");
        send_string("\\");
        send_string("\\n\\777");
        send_string("\\uu0141");
        send_string("\\ux");
        send_string("\\12");

        // Random strings
        while (sent_words < WORD_COUNT) begin
            steady = ($urandom_range(0, 7) == 0);
            build_string();
            send_text_q();
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        // Drain outstanding results
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("[string_escape_decoder] OK");
        end else begin
            $display("[string_escape_decoder] ERROR");
        end
        $finish;
    end

endmodule
